@@ hdl/stb_pkg.sv @@
// Shared types and constants of the software timer bank.
package stb_pkg;

    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 3;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_START   = 2'd1,
        CMD_DESTROY = 2'd2,
        CMD_TICK    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FREE     = 2'd1,
        ST_NOT_CREATED = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [2:0]  timer_id;
        logic [31:0] interval_ms;
        logic [31:0] start_delay_ms;
        logic        delay_enable;
        logic        repeat_enable;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [2:0] slot_id;
        logic       fired;
        logic       last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PRIME,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic flush;
    } t_dp_ctl;

    typedef struct packed {
        logic in_is_tick;
        logic out_free;
        logic fire;
        logic pend_valid;
        logic scan_done;
    } t_dp_sts;

endpackage

@@ hdl/software_timer_bank_core.sv @@
// Top level of the software timer bank: controller and datapath.
//
// A bank of TIMERS timer slots. Create, start and destroy items each give one
// result. In a tick item, while the output side keeps up, slots are evaluated
// one per cycle, in ascending order, through the single read port of the stamp
// and interval memories, after the S_PRIME state
// primes that read. Each firing gives one result; the most recent firing is held
// back one step so the final result of a tick carries last, and a tick stops
// after its eighth firing. A tick in which nothing fires gives no result.
// Results leave through one output register; the next item is accepted once the
// previous one has been worked off, even while its last result still waits.
module software_timer_bank_core import stb_pkg::*; #(
    parameter int TIMERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    stb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    stb_dp #(.TIMERS(TIMERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

@@ hdl/stb_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/stb_dp.sv @@
// Datapath of the timer bank: slot flags, stamp and interval memories, result register.
module stb_dp import stb_pkg::*; #(
    parameter int TIMERS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_ctl   i_ctl,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int IW = (W > 3) ? W : 3;
    localparam logic [W-1:0] LAST_IDX = W'(TIMERS - 1);
    localparam logic [IW:0]  NSLOT    = (IW + 1)'(TIMERS);

    t_in_item r_item;

    logic [TIMERS-1:0] r_used;
    logic [TIMERS-1:0] r_armed;
    logic [TIMERS-1:0] r_done;
    logic [TIMERS-1:0] r_svalid;
    logic [TIMERS-1:0] r_don;
    logic [TIMERS-1:0] r_rep;

    logic [W-1:0]     r_idx;
    logic [W-1:0]     nxt_idx;
    logic [W-1:0]     raddr;
    logic [CNT_W-1:0] r_cnt;

    logic         r_pend_valid;
    logic [2:0]   r_pend_id;
    logic         r_out_valid;
    t_out_item    r_out;
    t_out_item    n_out;
    t_out_item    cmd_out;
    logic         out_load;
    logic         out_free;

    logic [31:0] stamp_rd;
    logic [63:0] cfg_rd;
    logic        stamp_we;
    logic        cfg_we;

    logic [W-1:0]  free_idx;
    logic          full;
    logic [IW-1:0] free_ext;
    logic [IW-1:0] id_ext;
    logic [W-1:0]  id_idx;
    logic          id_ok;
    logic [IW-1:0] idx_ext;

    logic        act;
    logic        dph;
    logic        sv;
    logic [31:0] base;
    logic [31:0] diff;
    logic [31:0] lim;
    logic        fire;

    always_comb begin
        free_idx = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = W'(i);
            end
        end
    end

    assign full     = &r_used;
    assign free_ext = IW'(free_idx);
    assign id_ext   = IW'(r_item.timer_id);
    assign id_idx   = id_ext[W-1:0];
    assign id_ok    = {1'b0, id_ext} < NSLOT;
    assign idx_ext  = IW'(r_idx);

    assign act  = r_used[r_idx] & r_armed[r_idx];
    assign dph  = r_don[r_idx] & ~r_done[r_idx];
    assign sv   = r_svalid[r_idx];
    assign base = sv ? stamp_rd : r_item.now_ms;
    assign diff = r_item.now_ms - base;
    assign lim  = dph ? cfg_rd[63:32] : cfg_rd[31:0];
    assign fire = act & (diff >= lim);

    assign nxt_idx = (r_idx == LAST_IDX) ? '0 : r_idx + W'(1);
    assign raddr   = i_ctl.scan ? nxt_idx : r_idx;

    assign stamp_we = i_ctl.scan & act & (dph ? (fire | ~sv) : (~fire & ~sv));
    assign cfg_we   = i_ctl.exec & (r_item.cmd == CMD_CREATE) & ~full;

    stb_ram #(.WIDTH(32), .DEPTH(TIMERS)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_idx),
        .i_wdata (r_item.now_ms),
        .i_raddr (raddr),
        .o_rdata (stamp_rd)
    );

    stb_ram #(.WIDTH(64), .DEPTH(TIMERS)) u_cfg_ram (
        .i_clk   (i_clk),
        .i_we    (cfg_we),
        .i_waddr (free_idx),
        .i_wdata ({r_item.start_delay_ms, r_item.interval_ms}),
        .i_raddr (raddr),
        .o_rdata (cfg_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_armed  <= '0;
            r_done   <= '0;
            r_svalid <= '0;
            r_don    <= '0;
            r_rep    <= '0;
        end else begin
            if (i_ctl.exec) begin
                unique case (r_item.cmd)
                    CMD_CREATE: begin
                        if (!full) begin
                            r_used[free_idx]   <= 1'b1;
                            r_armed[free_idx]  <= 1'b0;
                            r_done[free_idx]   <= 1'b0;
                            r_svalid[free_idx] <= 1'b0;
                            r_don[free_idx]    <= r_item.delay_enable;
                            r_rep[free_idx]    <= r_item.repeat_enable;
                        end
                    end
                    CMD_START: begin
                        if (id_ok && r_used[id_idx]) begin
                            r_armed[id_idx] <= 1'b1;
                        end
                    end
                    CMD_DESTROY: begin
                        if (id_ok) begin
                            r_used[id_idx]   <= 1'b0;
                            r_armed[id_idx]  <= 1'b0;
                            r_done[id_idx]   <= 1'b0;
                            r_svalid[id_idx] <= 1'b0;
                            r_don[id_idx]    <= 1'b0;
                            r_rep[id_idx]    <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_ctl.scan && act) begin
                if (dph) begin
                    r_svalid[r_idx] <= 1'b1;
                    if (fire) begin
                        r_done[r_idx] <= 1'b1;
                    end
                end else if (fire) begin
                    r_svalid[r_idx] <= 1'b0;
                    if (!r_rep[r_idx]) begin
                        r_used[r_idx]  <= 1'b0;
                        r_armed[r_idx] <= 1'b0;
                        r_done[r_idx]  <= 1'b0;
                        r_don[r_idx]   <= 1'b0;
                    end
                end else begin
                    r_svalid[r_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_ctl.capture) begin
            r_idx        <= '0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
        end else if (i_ctl.scan) begin
            r_idx <= nxt_idx;
            if (fire) begin
                r_cnt        <= r_cnt + CNT_W'(1);
                r_pend_valid <= 1'b1;
            end
        end else if (i_ctl.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan && fire) begin
            r_pend_id <= idx_ext[2:0];
        end
    end

    always_comb begin
        cmd_out.fired = 1'b0;
        cmd_out.last  = 1'b1;
        unique case (r_item.cmd)
            CMD_CREATE: begin
                cmd_out.status  = full ? ST_NO_FREE : ST_OK;
                cmd_out.slot_id = full ? 3'd0 : free_ext[2:0];
            end
            CMD_START: begin
                cmd_out.status  = (id_ok && r_used[id_idx]) ? ST_OK : ST_NOT_CREATED;
                cmd_out.slot_id = r_item.timer_id;
            end
            default: begin
                cmd_out.status  = ST_OK;
                cmd_out.slot_id = r_item.timer_id;
            end
        endcase
    end

    always_comb begin
        if (i_ctl.exec) begin
            n_out = cmd_out;
        end else begin
            n_out.status  = ST_OK;
            n_out.slot_id = r_pend_id;
            n_out.fired   = 1'b1;
            n_out.last    = i_ctl.flush;
        end
    end

    assign out_load = i_ctl.exec | i_ctl.flush | (i_ctl.scan & fire & r_pend_valid);
    assign out_free = ~r_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_sts.in_is_tick = (i_in_item.cmd == CMD_TICK);
    assign o_sts.out_free   = out_free;
    assign o_sts.fire       = fire;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.scan_done  = (r_idx == LAST_IDX) |
                              (fire & (r_cnt == CNT_W'(MAX_RESULTS - 1)));

endmodule

@@ hdl/stb_ctrl.sv @@
// Controller of the timer bank: sequences commands and the tick scan.
module stb_ctrl import stb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl
);

    t_state r_state;
    t_state n_state;
    logic   stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign stall = i_sts.fire & i_sts.pend_valid & ~i_sts.out_free;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = i_sts.in_is_tick ? S_PRIME : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_PRIME: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (!stall) begin
                    o_ctl.scan = 1'b1;
                    if (i_sts.scan_done) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_ctl.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the software timer bank core.
module tb;
    import stb_pkg::*;

    localparam int TIMERS    = 8;
    localparam int LONG_HOLD = 160;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    logic      gap_on    = 1'b1;
    logic      stall_on  = 1'b1;
    logic      hold_req  = 1'b0;
    int        mismatches = 0;
    logic [31:0] clock_ms = 32'hFFFF_FF00;

    t_out_item expected_results[$];

    logic        slot_busy [TIMERS];
    logic        slot_run  [TIMERS];
    logic        wait_over [TIMERS];
    logic        t0_ok     [TIMERS];
    logic        base_ok   [TIMERS];
    logic        dly_en    [TIMERS];
    logic        rep_en    [TIMERS];
    logic [31:0] t0_stamp  [TIMERS];
    logic [31:0] base_stamp[TIMERS];
    logic [31:0] ivl_ms    [TIMERS];
    logic [31:0] dly_ms    [TIMERS];

    software_timer_bank_core #(.TIMERS(TIMERS)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic clear_slot_model(input int s);
        slot_busy[s]  = 1'b0;
        slot_run[s]   = 1'b0;
        wait_over[s]  = 1'b0;
        t0_ok[s]      = 1'b0;
        base_ok[s]    = 1'b0;
        dly_en[s]     = 1'b0;
        rep_en[s]     = 1'b0;
        t0_stamp[s]   = '0;
        base_stamp[s] = '0;
        ivl_ms[s]     = '0;
        dly_ms[s]     = '0;
    endtask

    // Advance the bank model by one item and queue the results it predicts.
    task automatic predict_bank(input t_in_item it);
        t_out_item   r;
        t_out_item   shots[$];
        int          s;
        int          free_slot;
        logic        hit;
        logic        drop;
        logic [31:0] age;
        r = '0;
        r.status = ST_OK;
        r.last = 1'b1;
        case (it.cmd)
            CMD_CREATE: begin
                free_slot = -1;
                for (s = TIMERS - 1; s >= 0; s--)
                    if (!slot_busy[s]) free_slot = s;
                if (free_slot < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    clear_slot_model(free_slot);
                    slot_busy[free_slot] = 1'b1;
                    ivl_ms[free_slot]    = it.interval_ms;
                    dly_ms[free_slot]    = it.start_delay_ms;
                    dly_en[free_slot]    = it.delay_enable;
                    rep_en[free_slot]    = it.repeat_enable;
                    r.slot_id = 3'(free_slot);
                end
                expected_results.push_back(r);
            end
            CMD_START: begin
                r.slot_id = it.timer_id;
                if (!slot_busy[it.timer_id]) r.status = ST_NOT_CREATED;
                else slot_run[it.timer_id] = 1'b1;
                expected_results.push_back(r);
            end
            CMD_DESTROY: begin
                clear_slot_model(int'(it.timer_id));
                r.slot_id = it.timer_id;
                expected_results.push_back(r);
            end
            default: begin
                for (s = 0; s < TIMERS && shots.size() < MAX_RESULTS; s++) begin
                    hit  = 1'b0;
                    drop = 1'b0;
                    if (slot_busy[s] && slot_run[s]) begin
                        if (dly_en[s] && !wait_over[s]) begin
                            if (!t0_ok[s]) begin
                                t0_stamp[s] = it.now_ms;
                                t0_ok[s]    = 1'b1;
                            end
                            age = it.now_ms - t0_stamp[s];
                            if (age >= dly_ms[s]) begin
                                hit           = 1'b1;
                                wait_over[s]  = 1'b1;
                                base_stamp[s] = it.now_ms;
                                base_ok[s]    = 1'b1;
                            end
                        end else begin
                            if (!base_ok[s]) begin
                                base_stamp[s] = it.now_ms;
                                base_ok[s]    = 1'b1;
                            end
                            age = it.now_ms - base_stamp[s];
                            if (age >= ivl_ms[s]) begin
                                hit        = 1'b1;
                                base_ok[s] = 1'b0;
                                drop       = !rep_en[s];
                            end
                        end
                    end
                    if (hit) begin
                        r = '0;
                        r.status  = ST_OK;
                        r.slot_id = 3'(s);
                        r.fired   = 1'b1;
                        shots.push_back(r);
                    end
                    if (drop) clear_slot_model(s);
                end
                if (shots.size() > 0) begin
                    r = shots.pop_back();
                    r.last = 1'b1;
                    shots.push_back(r);
                end
                foreach (shots[k]) expected_results.push_back(shots[k]);
            end
        endcase
    endtask

    task automatic send_item(input t_in_item it);
        if (gap_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        predict_bank(it);
    endtask

    function automatic t_in_item make_item(t_cmd c, logic [2:0] id, logic [31:0] ivl,
                                           logic [31:0] dly, logic den, logic ren,
                                           logic [31:0] now);
        t_in_item it;
        it.cmd            = c;
        it.timer_id       = id;
        it.interval_ms    = ivl;
        it.start_delay_ms = dly;
        it.delay_enable   = den;
        it.repeat_enable  = ren;
        it.now_ms         = now;
        return it;
    endfunction

    function automatic logic [31:0] rand_span();
        case ($urandom_range(0, 19))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF;
            2, 3:    return 32'd0;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Mostly create/start pairs and ticks on a running clock; some noise.
    task automatic random_timer_item(output t_in_item it);
        int          pick;
        int          s;
        int          idle_slot;
        int          n_busy;
        logic [31:0] junk;
        junk = $urandom();
        it = make_item(CMD_TICK, 3'($urandom_range(0, 7)), $urandom(), $urandom(),
                       1'($urandom()), 1'($urandom()), junk);
        idle_slot = -1;
        n_busy = 0;
        for (s = 0; s < TIMERS; s++) begin
            if (slot_busy[s]) n_busy++;
            if (slot_busy[s] && !slot_run[s]) idle_slot = s;
        end
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            it.cmd            = CMD_CREATE;
            it.interval_ms    = rand_span();
            it.start_delay_ms = rand_span();
        end else if (pick < 38) begin
            it.cmd = CMD_START;
            if (idle_slot >= 0 && $urandom_range(0, 4) != 0) it.timer_id = 3'(idle_slot);
        end else if (pick < 46 || (n_busy == TIMERS && pick < 52)) begin
            it.cmd = CMD_DESTROY;
        end else if ($urandom_range(0, 19) == 0) begin
            it.cmd = CMD_TICK;
        end else begin
            it.cmd   = CMD_TICK;
            clock_ms = clock_ms + $urandom_range(0, 25);
            it.now_ms = clock_ms;
        end
    endtask

    task automatic test_fill_bank();
        int i;
        for (i = 0; i < TIMERS; i++)
            send_item(make_item(CMD_CREATE, 3'd0,
                                (i < 4) ? 32'd0 : 32'hFFFF_FFFF,
                                (i < 4) ? 32'hFFFF_FFFF : 32'd0,
                                i >= 4, i[0], 32'd0));
        send_item(make_item(CMD_CREATE, 3'd7, 32'd5, 32'd5, 1'b1, 1'b1, 32'hFFFF_FFFF));
    endtask

    task automatic test_arm_all();
        int i;
        for (i = 0; i < TIMERS; i++)
            send_item(make_item(CMD_START, 3'(i), 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
        send_item(make_item(CMD_START, 3'd3, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    endtask

    task automatic test_tick_all_fire();
        send_item(make_item(CMD_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF));
    endtask

    task automatic test_bad_handles();
        send_item(make_item(CMD_START, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
        send_item(make_item(CMD_DESTROY, 3'd2, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
        send_item(make_item(CMD_DESTROY, 3'd7, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
        send_item(make_item(CMD_TICK, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0));
    endtask

    task automatic test_backpressure();
        t_in_item it;
        int       i;
        hold_req = 1'b1;
        for (i = 0; i < 24; i++) begin
            random_timer_item(it);
            send_item(it);
        end
    endtask

    task automatic test_random_bursty();
        t_in_item it;
        int       i;
        for (i = 0; i < 250; i++) begin
            random_timer_item(it);
            send_item(it);
        end
    endtask

    task automatic test_random_steady();
        t_in_item it;
        int       i;
        gap_on   = 1'b0;
        stall_on = 1'b0;
        for (i = 0; i < 90; i++) begin
            random_timer_item(it);
            send_item(it);
        end
    endtask

    initial begin
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d slot_id %0d fired %0d last %0d",
                       out_item.status, out_item.slot_id, out_item.fired, out_item.last);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (out_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, out_item.status);
                    mismatches++;
                end
                if (out_item.slot_id !== want.slot_id) begin
                    $error("slot_id: expected %0d, actual %0d", want.slot_id, out_item.slot_id);
                    mismatches++;
                end
                if (out_item.fired !== want.fired) begin
                    $error("fired: expected %0d, actual %0d", want.fired, out_item.fired);
                    mismatches++;
                end
                if (out_item.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, out_item.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int s;
        for (s = 0; s < TIMERS; s++) clear_slot_model(s);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_bank();
        test_arm_all();
        test_tick_all_fire();
        test_bad_handles();
        test_backpressure();
        test_random_bursty();
        test_random_steady();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
